>>> hw/rtl/lpht_pkg.sv
// Shared types and constants of the linear-probe hash table.
// Used by every module of the block; depends on nothing else.
package lpht_pkg;

    localparam int KEY_W   = 31;
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 5;
    localparam int ACT_W   = 2;
    localparam int MARK_W  = 2;
    localparam int STAT_W  = 2;

    // The size register cannot address more slots than this.
    localparam int MAX_USED = (1 << CFG_W) - 1;

    localparam logic [CFG_W-1:0] TSIZE_RESET = 5'd10;
    localparam logic [VAL_W-1:0] NO_VALUE    = {VAL_W{1'b1}};

    // Stream packing.
    localparam int IN_TDATA_W  = ((KEY_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_BITS    = 1 + VAL_W + STAT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

    // Modulo unit: two quotient bits per cycle over a zero-extended key.
    localparam int DIV_W     = KEY_W + 1;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
    localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
    localparam logic [MARK_W-1:0] MARK_GONE  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd2;

    // One write into the slot store.
    typedef struct packed {
        logic              key_we;
        logic              val_we;
        logic              mark_we;
        logic [CFG_W-1:0]  addr;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [MARK_W-1:0] mark;
    } slot_wr_t;

endpackage

>>> hw/rtl/lpht_mod.sv
// Iterative modulo unit: key modulo table size, two bits per cycle.
// Depends on lpht_pkg.
module lpht_mod (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lpht_pkg::KEY_W-1:0] dividend,
    input  logic [lpht_pkg::CFG_W-1:0] divisor,
    output logic [lpht_pkg::CFG_W-1:0] rem,
    output logic                       done
);
    import lpht_pkg::*;

    logic [DIV_W-1:0]     num_reg;
    logic [CFG_W-1:0]     rem_reg;
    logic [CFG_W-1:0]     div_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [CFG_W:0] t1, r1, t2, r2;

    // Two restoring steps; the partial remainder always stays below the divisor.
    always_comb
    begin
        t1 = {rem_reg, num_reg[DIV_W-1]};
        r1 = (t1 >= {1'b0, div_reg}) ? t1 - {1'b0, div_reg} : t1;
        t2 = {r1[CFG_W-1:0], num_reg[DIV_W-2]};
        r2 = (t2 >= {1'b0, div_reg}) ? t2 - {1'b0, div_reg} : t2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {1'b0, dividend};
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_W-3:0], 2'b00};
            rem_reg <= r2[CFG_W-1:0];
        end
    end

    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

>>> hw/rtl/lpht_slots.sv
// Slot store: key and value memories with registered reads, and slot marks.
// Depends on lpht_pkg.
module lpht_slots #(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lpht_pkg::slot_wr_t         wr,
    input  logic [lpht_pkg::CFG_W-1:0] rd_addr,
    output logic [lpht_pkg::KEY_W-1:0] rd_key,
    output logic [lpht_pkg::VAL_W-1:0] rd_val,
    output logic [lpht_pkg::MARK_W-1:0] rd_mark
);
    import lpht_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [KEY_W-1:0]  key_mem [DEPTH];
    logic [VAL_W-1:0]  val_mem [DEPTH];
    logic [MARK_W-1:0] marks_reg [DEPTH];

    logic [KEY_W-1:0]  rd_key_reg;
    logic [VAL_W-1:0]  rd_val_reg;
    logic [MARK_W-1:0] rd_mark_reg;

    always_ff @(posedge clk)
    begin
        if (wr.key_we)
        begin
            key_mem[wr.addr[IW-1:0]] <= wr.key;
        end
        if (wr.val_we)
        begin
            val_mem[wr.addr[IW-1:0]] <= wr.value;
        end
        rd_key_reg  <= key_mem[rd_addr[IW-1:0]];
        rd_val_reg  <= val_mem[rd_addr[IW-1:0]];
        rd_mark_reg <= marks_reg[rd_addr[IW-1:0]];
    end

    // Marks reset to empty at once, so the table starts cleared.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                marks_reg[i] <= MARK_EMPTY;
            end
        end
        else if (wr.mark_we)
        begin
            marks_reg[wr.addr[IW-1:0]] <= wr.mark;
        end
    end

    assign rd_key  = rd_key_reg;
    assign rd_val  = rd_val_reg;
    assign rd_mark = rd_mark_reg;

endmodule

>>> hw/rtl/linear_probe_hash_table.sv
// Linear-probe hash table. A request passes through the shared modulo unit (two
// bits a cycle), a step that starts the probe, P probe steps with one registered
// slot read each, where P is the number of slots probed (1 to the table size, at
// most 16), and a final step that loads the result. The input is ready again the
// cycle after the result is loaded, so the block takes one request at a time; an
// unused action skips the modulo unit and the probe and only loads its result.
// A stalled result holds the block in its finishing cycle until the result drains.
// Reset (asynchronous, active low) marks every slot empty at once and sets the
// table size to 10; no clearing pass is needed.
module linear_probe_hash_table #(
    parameter int SLOTS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration: table size.
    input  logic                                cfg_we,
    input  logic [lpht_pkg::CFG_W-1:0]          cfg_wdata,
    // Request stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lpht_pkg::IN_TDATA_W-1:0]     s_tdata,  // key[30:0], value[62:31], pad
    input  logic [lpht_pkg::ACT_W-1:0]          s_tuser,  // action[1:0]
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lpht_pkg::OUT_TDATA_W-1:0]    m_tdata   // found[0], read_value[32:1],
                                                          // status[34:33], pad
);
    import lpht_pkg::*;

    // Slots beyond what the size register can reach are never used.
    localparam int DEPTH = (SLOTS < MAX_USED) ? SLOTS : MAX_USED;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DIV    = 2'd1;
    localparam logic [1:0] ST_PROBE  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CFG_W-1:0] tsize_reg;
    logic [CFG_W-1:0] n_cfg;
    logic [CFG_W-1:0] n_reg;
    logic [ACT_W-1:0] act_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;

    // Probe bookkeeping.
    logic [CFG_W-1:0] cur_reg;
    logic [CFG_W-1:0] cnt_reg;
    logic             free_v_reg;
    logic [CFG_W-1:0] free_reg;
    logic             hit_reg;
    logic [CFG_W-1:0] hit_idx_reg;
    logic [VAL_W-1:0] hit_val_reg;

    // Result register.
    logic              m_valid_reg;
    logic              found_reg;
    logic [VAL_W-1:0]  rv_reg;
    logic [STAT_W-1:0] status_reg;

    logic              accept;
    logic              act_valid;
    logic              mod_done;
    logic [CFG_W-1:0]  mod_rem;
    logic [CFG_W-1:0]  rd_addr;
    logic [KEY_W-1:0]  rd_key;
    logic [VAL_W-1:0]  rd_val;
    logic [MARK_W-1:0] rd_mark;
    slot_wr_t          wr;

    logic              is_empty, is_used, match, last, stop, free_take;
    logic [CFG_W-1:0]  next_idx;
    logic              out_load;
    logic              found_next;
    logic [VAL_W-1:0]  rv_next;
    logic [STAT_W-1:0] status_next;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign act_valid = (s_tuser == ACT_INSERT) || (s_tuser == ACT_SEARCH)
                       || (s_tuser == ACT_REMOVE);

    // A size of zero acts as one slot; a size beyond the store acts as the whole store.
    always_comb
    begin
        if (tsize_reg == '0)
        begin
            n_cfg = CFG_W'(1);
        end
        else if (int'(tsize_reg) > DEPTH)
        begin
            n_cfg = CFG_W'(DEPTH);
        end
        else
        begin
            n_cfg = tsize_reg;
        end
    end

    lpht_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && act_valid),
        .dividend (s_tdata[KEY_W-1:0]),
        .divisor  (n_cfg),
        .rem      (mod_rem),
        .done     (mod_done)
    );

    lpht_slots #(
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_val  (rd_val),
        .rd_mark (rd_mark)
    );

    // The slot read in the probe state belongs to cur_reg. The next slot on the
    // chain is read at the same time, since a probe that goes on always moves there.
    always_comb
    begin
        is_empty  = (rd_mark == MARK_EMPTY);
        is_used   = (rd_mark == MARK_USED);
        match     = is_used && (rd_key == key_reg);
        last      = (cnt_reg == n_reg - CFG_W'(1));
        stop      = is_empty || match || last;
        free_take = !free_v_reg && !is_used;
        next_idx  = (cur_reg == n_reg - CFG_W'(1)) ? '0 : cur_reg + CFG_W'(1);
        rd_addr   = (state_reg == ST_DIV) ? mod_rem : next_idx;
    end

    // The finishing cycle loads the result register when it is free or being
    // drained, and commits the write in the same cycle.
    assign out_load = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);

    always_comb
    begin
        wr          = '0;
        wr.key      = key_reg;
        wr.value    = val_reg;
        wr.mark     = MARK_USED;
        wr.addr     = hit_reg ? hit_idx_reg : free_reg;
        found_next  = 1'b0;
        rv_next     = NO_VALUE;
        status_next = STAT_OK;
        unique case (act_reg)
            ACT_INSERT:
            begin
                found_next = hit_reg;
                if (hit_reg)
                begin
                    wr.val_we = out_load;
                end
                else if (free_v_reg)
                begin
                    wr.key_we  = out_load;
                    wr.val_we  = out_load;
                    wr.mark_we = out_load;
                end
                else
                begin
                    status_next = STAT_FULL;
                end
            end
            ACT_SEARCH:
            begin
                found_next  = hit_reg;
                rv_next     = hit_reg ? hit_val_reg : NO_VALUE;
                status_next = hit_reg ? STAT_OK : STAT_ABSENT;
            end
            ACT_REMOVE:
            begin
                found_next  = hit_reg;
                status_next = hit_reg ? STAT_OK : STAT_ABSENT;
                wr.mark     = MARK_GONE;
                wr.mark_we  = out_load && hit_reg;
            end
            default:
            begin
                found_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = act_valid ? ST_DIV : ST_FINISH;
                end
            end
            ST_DIV:
            begin
                if (mod_done)
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (stop)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            tsize_reg   <= TSIZE_RESET;
            m_valid_reg <= 1'b0;
            hit_reg     <= 1'b0;
            free_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                tsize_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                hit_reg    <= 1'b0;
                free_v_reg <= 1'b0;
            end
            else if (state_reg == ST_PROBE)
            begin
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
                if (free_take)
                begin
                    free_v_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= s_tuser;
            key_reg <= s_tdata[KEY_W-1:0];
            val_reg <= s_tdata[KEY_W +: VAL_W];
            n_reg   <= n_cfg;
        end
        if (state_reg == ST_DIV && mod_done)
        begin
            cur_reg <= mod_rem;
            cnt_reg <= '0;
        end
        else if (state_reg == ST_PROBE)
        begin
            cur_reg <= next_idx;
            cnt_reg <= cnt_reg + CFG_W'(1);
            if (match)
            begin
                hit_idx_reg <= cur_reg;
                hit_val_reg <= rd_val;
            end
            if (free_take)
            begin
                free_reg <= cur_reg;
            end
        end
        if (out_load)
        begin
            found_reg  <= found_next;
            rv_reg     <= rv_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, status_reg, rv_reg, found_reg};

endmodule

>>> hw/rtl/lpht_chk.sv
// Port-level checks of the linear-probe hash table, bound to its top level.
// Depends on lpht_pkg and linear_probe_hash_table.
module lpht_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [lpht_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import lpht_pkg::*;

    logic              found;
    logic [VAL_W-1:0]  read_value;
    logic [STAT_W-1:0] status;

    assign found      = m_tdata[0];
    assign read_value = m_tdata[VAL_W:1];
    assign status     = m_tdata[VAL_W+STAT_W:VAL_W+1];

    // A held result keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One request at a time: the block is busy right after taking one.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (status == STAT_OK) || (status == STAT_FULL)
                     || (status == STAT_ABSENT))
        else $error("undefined status code");

    // A full table means the key was absent and no value is returned.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && status == STAT_FULL |-> !found && read_value == NO_VALUE)
        else $error("full result inconsistent");

    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && found |-> status == STAT_OK)
        else $error("found key reported with error status");

endmodule

bind linear_probe_hash_table lpht_chk u_lpht_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
